// ===== rtl/u16l1_pkg.sv =====
// shared types, codes and byte helpers for the utf-16le / latin-1 to utf-8 transcoder
`default_nettype none
package u16l1_pkg;

  // default number of entries in the job queue between front and back
  localparam int unsigned JobQueueDepth = 4;

  // done status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_EMPTY     = 3'd1;
  localparam logic [2:0] ST_BAD_ENC   = 3'd2;
  localparam logic [2:0] ST_ODD_LEN   = 3'd3;
  localparam logic [2:0] ST_TRUNC     = 3'd4;
  localparam logic [2:0] ST_BAD_LOW   = 3'd5;
  localparam logic [2:0] ST_LONE_LOW  = 3'd6;

  // encoding selector values
  localparam logic [7:0] SEL_UTF16  = 8'h00;
  localparam logic [7:0] SEL_LATIN1 = 8'h01;

  // surrogate prefixes of a utf-16 code unit
  localparam logic [5:0] HIGH_SURR_PREFIX = 6'b110110;
  localparam logic [5:0] LOW_SURR_PREFIX  = 6'b110111;
  localparam logic [20:0] SUPP_BASE       = 21'h10000;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first;
    logic       last;
    logic       empty_string;
  } item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic [2:0] status;
    logic       run_last;
  } result_t;

  // one unit of work for the back end: a code point and/or a done result
  typedef struct packed {
    logic        has_cp;
    logic [20:0] cp;
    logic [1:0]  nbytes_m1;
    logic        done;
    logic [2:0]  status;
  } job_t;

  // utf-8 length minus one for a code point
  function automatic logic [1:0] utf8_len_m1(input logic [20:0] cp);
    logic [1:0] n;
    if (cp[20:16] != 5'd0) n = 2'd3;
    else if (cp[15:11] != 5'd0) n = 2'd2;
    else if (cp[10:7] != 4'd0) n = 2'd1;
    else n = 2'd0;
    return n;
  endfunction

  // utf-8 byte number idx of a code point whose length minus one is n
  function automatic logic [7:0] utf8_byte(input logic [20:0] cp, input logic [1:0] n,
                                           input logic [1:0] idx);
    logic [7:0] b;
    b = 8'h00;
    case (n)
      2'd0: b = {1'b0, cp[6:0]};
      2'd1: begin
        case (idx)
          2'd0: b = {3'b110, cp[10:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      2'd2: begin
        case (idx)
          2'd0: b = {4'b1110, cp[15:12]};
          2'd1: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
      default: begin
        case (idx)
          2'd0: b = {5'b11110, cp[20:18]};
          2'd1: b = {2'b10, cp[17:12]};
          2'd2: b = {2'b10, cp[11:6]};
          default: b = {2'b10, cp[5:0]};
        endcase
      end
    endcase
    return b;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/u16l1_front.sv =====
// front end: takes input items, tracks string state and forms jobs
`default_nettype none
module u16l1_front import u16l1_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire logic  accept,
  input  wire item_t item,
  output logic       job_push,
  output job_t       job
);

  logic        string_open, string_open_next;
  logic        utf16_mode, utf16_mode_next;
  logic        have_low_half, have_low_half_next;
  logic [7:0]  held_low_byte, held_low_byte_next;
  logic        have_high_surrogate, have_high_surrogate_next;
  logic [9:0]  high_surrogate_bits, high_surrogate_bits_next;
  logic [2:0]  error_latch, error_latch_next;

  logic [15:0] unit;
  logic [20:0] cp;
  logic        cp_valid;
  logic        close;
  logic [2:0]  fin_status;

  assign unit = {item.data_byte, held_low_byte};

  // next string state and the job for this item
  always_comb begin
    string_open_next         = string_open;
    utf16_mode_next          = utf16_mode;
    have_low_half_next       = have_low_half;
    held_low_byte_next       = held_low_byte;
    have_high_surrogate_next = have_high_surrogate;
    high_surrogate_bits_next = high_surrogate_bits;
    error_latch_next         = error_latch;
    cp       = 21'd0;
    cp_valid = 1'b0;
    close    = 1'b0;
    fin_status = ST_OK;

    if (accept && !item.empty_string) begin
      if (item.first) begin
        string_open_next         = 1'b1;
        utf16_mode_next          = 1'b0;
        have_low_half_next       = 1'b0;
        held_low_byte_next       = 8'd0;
        have_high_surrogate_next = 1'b0;
        high_surrogate_bits_next = 10'd0;
        error_latch_next         = ST_OK;
        if (item.data_byte == SEL_UTF16) utf16_mode_next = 1'b1;
        else if (item.data_byte != SEL_LATIN1) error_latch_next = ST_BAD_ENC;
      end else if (string_open) begin
        if (utf16_mode) begin
          if (!have_low_half) begin
            held_low_byte_next = item.data_byte;
            have_low_half_next = 1'b1;
          end else begin
            have_low_half_next = 1'b0;
            if (error_latch == ST_OK) begin
              // surrogate pairing
              if (have_high_surrogate) begin
                have_high_surrogate_next = 1'b0;
                high_surrogate_bits_next = 10'd0;
                if (unit[15:10] == LOW_SURR_PREFIX) begin
                  cp       = SUPP_BASE + {1'b0, high_surrogate_bits, unit[9:0]};
                  cp_valid = 1'b1;
                end else begin
                  error_latch_next = ST_BAD_LOW;
                end
              end else if (unit[15:10] == HIGH_SURR_PREFIX) begin
                have_high_surrogate_next = 1'b1;
                high_surrogate_bits_next = unit[9:0];
              end else if (unit[15:10] == LOW_SURR_PREFIX) begin
                error_latch_next = ST_LONE_LOW;
              end else begin
                cp       = {5'd0, unit};
                cp_valid = 1'b1;
              end
            end
          end
        end else if (error_latch == ST_OK) begin
          cp       = {13'd0, item.data_byte};
          cp_valid = 1'b1;
        end
      end

      // closing status from the updated state
      if (item.last && (item.first || string_open)) begin
        close = 1'b1;
        if (error_latch_next == ST_BAD_ENC) fin_status = ST_BAD_ENC;
        else if (utf16_mode_next && have_low_half_next) fin_status = ST_ODD_LEN;
        else if (error_latch_next != ST_OK) fin_status = error_latch_next;
        else if (have_high_surrogate_next) fin_status = ST_TRUNC;
        else fin_status = ST_OK;
      end
    end

    if (accept && item.empty_string) begin
      close      = 1'b1;
      fin_status = ST_EMPTY;
    end

    // a closed string leaves nothing behind
    if (close) begin
      string_open_next         = 1'b0;
      utf16_mode_next          = 1'b0;
      have_low_half_next       = 1'b0;
      held_low_byte_next       = 8'd0;
      have_high_surrogate_next = 1'b0;
      high_surrogate_bits_next = 10'd0;
      error_latch_next         = ST_OK;
    end
  end

  // job towards the queue
  always_comb begin
    job.has_cp    = cp_valid;
    job.cp        = cp;
    job.nbytes_m1 = utf8_len_m1(cp);
    job.done      = close;
    job.status    = fin_status;
    job_push      = cp_valid || close;
  end

  // string state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      string_open         <= 1'b0;
      utf16_mode          <= 1'b0;
      have_low_half       <= 1'b0;
      held_low_byte       <= 8'd0;
      have_high_surrogate <= 1'b0;
      high_surrogate_bits <= 10'd0;
      error_latch         <= ST_OK;
    end else begin
      string_open         <= string_open_next;
      utf16_mode          <= utf16_mode_next;
      have_low_half       <= have_low_half_next;
      held_low_byte       <= held_low_byte_next;
      have_high_surrogate <= have_high_surrogate_next;
      high_surrogate_bits <= high_surrogate_bits_next;
      error_latch         <= error_latch_next;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/u16l1_job_queue.sv =====
// short first-in first-out queue of jobs between front and back
`default_nettype none
module u16l1_job_queue import u16l1_pkg::*; #(
  parameter int unsigned DEPTH = JobQueueDepth
) (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic wr_en,
  input  wire job_t wr_data,
  output logic      full,
  output logic      rd_valid,
  output job_t      rd_data,
  input  wire logic rd_en
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  job_t          entries [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_wr;
  logic          do_rd;

  assign full     = (count == CW'(DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = entries[rd_ptr];
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && rd_valid;

  // storage
  always_ff @(posedge clk) begin
    if (do_wr) entries[wr_ptr] <= wr_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_wr) wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (do_rd) rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (do_wr && !do_rd) count <= count + 1'b1;
      else if (do_rd && !do_wr) count <= count - 1'b1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/u16l1_back.sv =====
// back end: turns jobs into utf-8 bytes and done results, one per cycle while its results are popped
`default_nettype none
module u16l1_back import u16l1_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic job_valid,
  input  wire job_t job,
  output logic      job_pop,
  output result_t   result,
  output logic      empty,
  input  wire logic pop
);

  logic       out_valid;
  logic [2:0] idx;
  logic       load;
  logic       is_byte;
  logic       job_end;
  result_t    res_next;

  assign empty = !out_valid;
  assign load  = job_valid && (!out_valid || pop);

  // pick the next result of the current job
  always_comb begin
    is_byte = job.has_cp && (idx <= {1'b0, job.nbytes_m1});
    job_end = is_byte ? ((idx[1:0] == job.nbytes_m1) && !job.done) : 1'b1;
    res_next.out_byte    = is_byte ? utf8_byte(job.cp, job.nbytes_m1, idx[1:0]) : 8'h00;
    res_next.byte_valid  = is_byte;
    res_next.string_done = !is_byte;
    res_next.status      = is_byte ? ST_OK : job.status;
    res_next.run_last    = job_end;
  end

  assign job_pop = load && job_end;

  // result register
  always_ff @(posedge clk) begin
    if (load) result <= res_next;
  end

  // result valid flag and position within the job
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 3'd0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (pop) out_valid <= 1'b0;
      if (load) idx <= job_end ? 3'd0 : idx + 3'd1;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/utf16le_latin1_to_utf8_transcoder.sv =====
// top level of the utf-16le / latin-1 to utf-8 transcoder
// An item is taken in any cycle in which the job queue between the front and
// back ends has room; the front end updates the string state in that same
// cycle. Each item causes 0 to 5 results (up to four utf-8 bytes and a done
// result), and the back end hands out one result per cycle while its results
// are popped, so it takes no new job before the last one has given all of its
// results. The back end has a single result register, and a result passes
// through the job queue and that register before it reaches the result ports.
`default_nettype none
module utf16le_latin1_to_utf8_transcoder import u16l1_pkg::*; #(
  parameter int unsigned JOB_DEPTH = JobQueueDepth
) (
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire item_t item,
  input  wire logic  push,
  output logic       full,
  output result_t    result,
  output logic       empty,
  input  wire logic  pop
);

  logic accept;
  logic job_push;
  job_t job_in;
  logic job_valid;
  job_t job_out;
  logic job_pop;

  assign accept = push && !full;

  // item classification and string state
  u16l1_front u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .item     (item),
    .job_push (job_push),
    .job      (job_in)
  );

  // decoupling queue
  u16l1_job_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (job_push),
    .wr_data  (job_in),
    .full     (full),
    .rd_valid (job_valid),
    .rd_data  (job_out),
    .rd_en    (job_pop)
  );

  // utf-8 serialiser
  u16l1_back u_back (
    .clk       (clk),
    .rst       (rst),
    .job_valid (job_valid),
    .job       (job_out),
    .job_pop   (job_pop),
    .result    (result),
    .empty     (empty),
    .pop       (pop)
  );

endmodule
`default_nettype wire
